>>> hw/rtl/afv_pkg.sv
// Shared constants for the aspect-fit viewport calculator.
// No dependencies; used by the channel interfaces and the top level.
package afv_pkg;

  localparam int DIM_BITS     = 13;
  localparam int PAR_BITS     = 16;
  localparam int OUT_BITS     = 16;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INSET_LEFT    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_INSET_TOP     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_INSET_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_INSET_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIXED_43      = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEEP_ASPECT   = 3'd7;

  localparam int MODE_BITS = 2;
  localparam logic [MODE_BITS-1:0] MODE_FULL   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_43     = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_LETTER = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_PILLAR = 2'd3;

  localparam int RATIO_W = 4;
  localparam int RATIO_H = 3;

endpackage

>>> hw/rtl/afv_frame_if.sv
// Input channel: one source frame descriptor per transfer.
// Depends on afv_pkg for default widths.
interface afv_frame_if #(
  parameter int DIM_BITS = afv_pkg::DIM_BITS,
  parameter int PAR_BITS = afv_pkg::PAR_BITS
) ();
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] frame_w;
  logic [DIM_BITS-1:0] frame_h;
  logic [PAR_BITS-1:0] pixel_aspect_num;
  logic [PAR_BITS-1:0] pixel_aspect_den;

  modport source (output valid, frame_w, frame_h, pixel_aspect_num, pixel_aspect_den,
                  input ready);
  modport sink (input valid, frame_w, frame_h, pixel_aspect_num, pixel_aspect_den,
                output ready);
endinterface

>>> hw/rtl/afv_view_if.sv
// Output channel: one viewport rectangle per transfer.
// Depends on afv_pkg for the result width.
interface afv_view_if ();
  logic                                valid;
  logic                                ready;
  logic signed [afv_pkg::OUT_BITS-1:0] view_x;
  logic signed [afv_pkg::OUT_BITS-1:0] view_y;
  logic        [afv_pkg::OUT_BITS-1:0] view_w;
  logic        [afv_pkg::OUT_BITS-1:0] view_h;
  logic                                saturated;

  modport source (output valid, view_x, view_y, view_w, view_h, saturated, input ready);
  modport sink (input valid, view_x, view_y, view_w, view_h, saturated, output ready);
endinterface

>>> hw/rtl/aspect_fit_viewport_calc.sv
// Top level of the aspect-fit viewport calculator.
// Depends on afv_pkg, afv_frame_if and afv_view_if.

// Accepts one frame descriptor per cycle while view_out back-pressure does not stall the
// pipeline, and returns one viewport per descriptor, in order. Q = max(17, DIM_BITS+5) is
// the number of quotient stages of the pipelined restoring divider. The pipeline is two
// multiplier stages, a fit-select stage, an overflow stage, one divider stage per quotient
// bit, an offset stage and the output register. Each stage holds only while the one after
// it is full and stalled, so bubbles are squeezed out and the input stays ready while a
// finished viewport waits, as long as some stage is empty. Configuration writes take effect
// at once and must only be made while no descriptor is in flight.
module aspect_fit_viewport_calc #(
  parameter int DIM_BITS = afv_pkg::DIM_BITS,
  parameter int PAR_BITS = afv_pkg::PAR_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [afv_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [DIM_BITS-1:0]               cfg_data,
  afv_frame_if.sink                         frame_in,
  afv_view_if.source                        view_out
);

  localparam int SW = DIM_BITS + PAR_BITS;
  localparam int NW = SW + DIM_BITS;
  localparam int QB = (DIM_BITS + 5 > 17) ? DIM_BITS + 5 : 17;
  localparam int RW = NW + QB;
  localparam int XW = QB + 3;
  localparam int OB = afv_pkg::OUT_BITS;
  localparam logic signed [XW-1:0] XMAX = XW'((1 << (OB - 1)) - 1);
  localparam logic signed [XW-1:0] XMIN = -XW'(1 << (OB - 1));
  localparam logic [QB-1:0] WMAX = QB'((1 << OB) - 1);

  // configuration registers
  logic [DIM_BITS-1:0] disp_w, disp_h, inset_l, inset_t, inset_wd, inset_ht;
  logic                fix43, keep_asp;

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_w   <= '0;
      disp_h   <= '0;
      inset_l  <= '0;
      inset_t  <= '0;
      inset_wd <= '0;
      inset_ht <= '0;
      fix43    <= 1'b0;
      keep_asp <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afv_pkg::REG_SCREEN_WIDTH:  disp_w   <= cfg_data;
        afv_pkg::REG_SCREEN_HEIGHT: disp_h   <= cfg_data;
        afv_pkg::REG_INSET_LEFT:    inset_l  <= cfg_data;
        afv_pkg::REG_INSET_TOP:     inset_t  <= cfg_data;
        afv_pkg::REG_INSET_WIDTH:   inset_wd <= cfg_data;
        afv_pkg::REG_INSET_HEIGHT:  inset_ht <= cfg_data;
        afv_pkg::REG_FIXED_43:      fix43    <= cfg_data[0];
        afv_pkg::REG_KEEP_ASPECT:   keep_asp <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage enables, back to front
  logic          o_en, p_en, e3, e2, e1;
  logic [QB:0]   d_en;
  logic          ov, pv, v3, v2, v1;
  logic [QB:0]   dv;

  assign o_en  = !ov || view_out.ready;
  assign p_en  = !pv || o_en;
  assign e3    = !v3 || d_en[0];
  assign e2    = !v2 || e3;
  assign e1    = !v1 || e2;
  assign frame_in.ready = e1;

  // stage 1: canvas and effective source size
  logic                inset_on;
  logic [PAR_BITS-1:0] pn_e, pd_e;
  logic [DIM_BITS-1:0] cw_c, ch_c;
  logic                par_zero;

  assign inset_on = (inset_wd != '0) && (inset_ht != '0);
  assign cw_c     = inset_on ? inset_wd : disp_w;
  assign ch_c     = inset_on ? inset_ht : disp_h;
  assign par_zero = (frame_in.pixel_aspect_num == '0) || (frame_in.pixel_aspect_den == '0);
  assign pn_e     = par_zero ? PAR_BITS'(1) : frame_in.pixel_aspect_num;
  assign pd_e     = par_zero ? PAR_BITS'(1) : frame_in.pixel_aspect_den;

  logic [SW-1:0]       s1_sw, s1_sh;
  logic [DIM_BITS-1:0] s1_cw, s1_ch;
  logic                s1_inset, s1_fnz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (e1) begin
      v1 <= frame_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      s1_sw    <= SW'(frame_in.frame_w) * SW'(pn_e);
      s1_sh    <= SW'(frame_in.frame_h) * SW'(pd_e);
      s1_cw    <= cw_c;
      s1_ch    <= ch_c;
      s1_inset <= inset_on;
      s1_fnz   <= (frame_in.frame_w != '0) && (frame_in.frame_h != '0);
    end
  end

  // stage 2: cross products
  logic [NW-1:0]       s2_lhs, s2_rhs;
  logic [SW-1:0]       s2_sw, s2_sh;
  logic [DIM_BITS-1:0] s2_cw, s2_ch;
  logic                s2_inset, s2_fnz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (e2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (e2) begin
      s2_lhs   <= NW'(s1_sw) * NW'(s1_ch);
      s2_rhs   <= NW'(s1_cw) * NW'(s1_sh);
      s2_sw    <= s1_sw;
      s2_sh    <= s1_sh;
      s2_cw    <= s1_cw;
      s2_ch    <= s1_ch;
      s2_inset <= s1_inset;
      s2_fnz   <= s1_fnz;
    end
  end

  // stage 3: pick the fit and the division to do
  logic [afv_pkg::MODE_BITS-1:0] mode_c;
  logic [NW-1:0]                 num_c;
  logic [SW-1:0]                 den_c;

  always_comb begin
    mode_c = afv_pkg::MODE_FULL;
    num_c  = '0;
    den_c  = SW'(1);
    if (fix43) begin
      mode_c = afv_pkg::MODE_43;
      num_c  = NW'(s2_ch) * NW'(afv_pkg::RATIO_W);
      den_c  = SW'(afv_pkg::RATIO_H);
    end else if (keep_asp && s2_fnz) begin
      if ((s2_lhs > s2_rhs) || ((s2_lhs < s2_rhs) && s2_inset)) begin
        mode_c = afv_pkg::MODE_LETTER;
        num_c  = s2_rhs;
        den_c  = s2_sw;
      end else if (s2_lhs < s2_rhs) begin
        mode_c = afv_pkg::MODE_PILLAR;
        num_c  = s2_lhs;
        den_c  = s2_sh;
      end
    end
  end

  logic [afv_pkg::MODE_BITS-1:0] s3_mode;
  logic [NW-1:0]                 s3_num;
  logic [SW-1:0]                 s3_den;
  logic [DIM_BITS-1:0]           s3_cw, s3_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (e3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (e3) begin
      s3_mode <= mode_c;
      s3_num  <= num_c;
      s3_den  <= den_c;
      s3_cw   <= s2_cw;
      s3_ch   <= s2_ch;
    end
  end

  // divider: overflow stage, then one quotient bit per stage
  logic [RW-1:0]                 drem  [QB+1];
  logic [SW-1:0]                 dden  [QB+1];
  logic [QB-1:0]                 dq    [QB+1];
  logic                          dovf  [QB+1];
  logic [DIM_BITS-1:0]           dcw   [QB+1];
  logic [DIM_BITS-1:0]           dch   [QB+1];
  logic [afv_pkg::MODE_BITS-1:0] dmode [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (d_en[0]) begin
      dv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (d_en[0]) begin
      drem[0]  <= RW'(s3_num);
      dden[0]  <= s3_den;
      dq[0]    <= '0;
      dovf[0]  <= RW'(s3_num) >= (RW'(s3_den) << QB);
      dcw[0]   <= s3_cw;
      dch[0]   <= s3_ch;
      dmode[0] <= s3_mode;
    end
  end

  for (genvar k = 0; k <= QB; k++) begin : g_den
    if (k < QB) begin : g_mid
      assign d_en[k] = !dv[k] || d_en[k+1];
    end else begin : g_last
      assign d_en[k] = !dv[k] || p_en;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [RW-1:0] trial;
    logic          take;

    assign trial = RW'(dden[k-1]) << (QB - k);
    assign take  = drem[k-1] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (d_en[k]) begin
        dv[k] <= dv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (d_en[k]) begin
        drem[k]  <= take ? drem[k-1] - trial : drem[k-1];
        dq[k]    <= dq[k-1] | (QB'(take) << (QB - k));
        dden[k]  <= dden[k-1];
        dovf[k]  <= dovf[k-1];
        dcw[k]   <= dcw[k-1];
        dch[k]   <= dch[k-1];
        dmode[k] <= dmode[k-1];
      end
    end
  end

  // offset stage: size from the quotient, centring offsets
  logic [QB-1:0]        q_eff, w_sel, h_sel, cw_q, ch_q;
  logic signed [XW-1:0] xd, yd, x_half, y_half;

  always_comb begin
    q_eff = dovf[QB] ? '1 : dq[QB];
    cw_q  = QB'(dcw[QB]);
    ch_q  = QB'(dch[QB]);
    w_sel = cw_q;
    h_sel = ch_q;
    case (dmode[QB])
      afv_pkg::MODE_43: begin
        if (q_eff > cw_q) begin
          w_sel = cw_q;
          h_sel = QB'((cw_q * QB'(afv_pkg::RATIO_H)) >> 2);
        end else begin
          w_sel = q_eff;
        end
      end
      afv_pkg::MODE_LETTER: h_sel = q_eff;
      afv_pkg::MODE_PILLAR: w_sel = q_eff;
      default: ;
    endcase
    xd     = $signed(XW'(cw_q)) - $signed(XW'(w_sel));
    yd     = $signed(XW'(ch_q)) - $signed(XW'(h_sel));
    x_half = (xd + $signed(XW'(xd[XW-1]))) >>> 1;
    y_half = (yd + $signed(XW'(yd[XW-1]))) >>> 1;
  end

  logic [QB-1:0]        pw, ph;
  logic signed [XW-1:0] px, py;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (p_en) begin
      pv <= dv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (p_en) begin
      pw <= w_sel;
      ph <= h_sel;
      px <= x_half;
      py <= y_half;
    end
  end

  // output register: add the inset offset and clamp
  logic signed [XW-1:0] xs, ys;
  logic signed [OB-1:0] x_cl, y_cl;
  logic [OB-1:0]        w_cl, h_cl;
  logic                 sat_c;

  always_comb begin
    xs    = px + $signed(XW'(inset_l));
    ys    = py + $signed(XW'(inset_t));
    sat_c = 1'b0;
    x_cl  = OB'(xs);
    y_cl  = OB'(ys);
    w_cl  = OB'(pw);
    h_cl  = OB'(ph);
    if (xs > XMAX) begin
      x_cl  = OB'(XMAX);
      sat_c = 1'b1;
    end else if (xs < XMIN) begin
      x_cl  = OB'(XMIN);
      sat_c = 1'b1;
    end
    if (ys > XMAX) begin
      y_cl  = OB'(XMAX);
      sat_c = 1'b1;
    end else if (ys < XMIN) begin
      y_cl  = OB'(XMIN);
      sat_c = 1'b1;
    end
    if (pw > WMAX) begin
      w_cl  = OB'(WMAX);
      sat_c = 1'b1;
    end
    if (ph > WMAX) begin
      h_cl  = OB'(WMAX);
      sat_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (o_en) begin
      ov <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      view_out.view_x    <= x_cl;
      view_out.view_y    <= y_cl;
      view_out.view_w    <= w_cl;
      view_out.view_h    <= h_cl;
      view_out.saturated <= sat_c;
    end
  end

  assign view_out.valid = ov;

endmodule
